>>> rtl/core/lhcg_pkg.sv
// shared constants, types and helpers for the lorentzian homography cost unit
// holds the log2 table built at elaboration and the saturation helpers
// no dependencies
package lhcg_pkg;

    localparam int FRAC_BITS      = 16;
    localparam int LOG_TABLE_BITS = 8;
    localparam int TAB_SIZE       = 1 << LOG_TABLE_BITS;
    localparam int LOG_FRAC       = 30;

    localparam logic [31:0] LN2_Q32 = 32'd2977044472;

    localparam logic [2:0] REG_NORMAL_X = 3'd0;
    localparam logic [2:0] REG_NORMAL_Y = 3'd1;
    localparam logic [2:0] REG_NORMAL_Z = 3'd2;
    localparam logic [2:0] REG_MOTION_X = 3'd3;
    localparam logic [2:0] REG_MOTION_Y = 3'd4;
    localparam logic [2:0] REG_MOTION_Z = 3'd5;
    localparam logic [2:0] REG_SIGMA    = 3'd6;

    typedef logic [31:0] log_tab_t [0:TAB_SIZE];

    // log2 of a Q2.30 value in [1,2] by repeated squaring
    function automatic logic [31:0] log2_q30(input logic [63:0] y_in);
        logic [63:0] y;
        logic [31:0] res;
        int          k;
        y   = y_in;
        res = 32'd0;
        if (y >= (64'd2 << LOG_FRAC)) begin
            y   = y >> 1;
            res = 32'd1 << LOG_FRAC;
        end
        for (k = LOG_FRAC - 1; k >= 0; k--) begin
            y = (y * y) >> LOG_FRAC;
            if (y >= (64'd2 << LOG_FRAC)) begin
                y   = y >> 1;
                res = res + (32'd1 << k);
            end
        end
        return res;
    endfunction

    function automatic log_tab_t build_log_tab();
        log_tab_t t;
        int       i;
        for (i = 0; i <= TAB_SIZE; i++) begin
            t[i] = log2_q30((64'(TAB_SIZE + i) << LOG_FRAC) >> LOG_TABLE_BITS);
        end
        return t;
    endfunction

    localparam log_tab_t LOG_TAB = build_log_tab();

    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        if (v > 64'sd2147483647) begin
            return 32'sh7fffffff;
        end else if (v < -64'sd2147483648) begin
            return 32'sh80000000;
        end
        return v[31:0];
    endfunction

    function automatic logic signed [31:0] sub_sat32(input logic signed [31:0] a,
                                                     input logic signed [31:0] b);
        logic signed [32:0] s;
        s = {a[31], a} - {b[31], b};
        return sat32({{31{s[32]}}, s});
    endfunction

    function automatic logic signed [31:0] add_sat32(input logic signed [31:0] a,
                                                     input logic signed [31:0] b);
        logic signed [32:0] s;
        s = {a[31], a} + {b[31], b};
        return sat32({{31{s[32]}}, s});
    endfunction

    function automatic logic signed [63:0] sat_add64(input logic signed [63:0] a,
                                                     input logic signed [63:0] b);
        logic signed [64:0] s;
        s = {a[63], a} + {b[63], b};
        if (s[64] != s[63]) begin
            return s[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
        end
        return s[63:0];
    endfunction

endpackage

>>> rtl/core/lorentzian_homography_cost_gradient_unit.sv
// top level of the lorentzian homography cost and gradient unit
// one multiplier, one restoring divider and a sequencer; uses lhcg_pkg
//
// usage
// - input stream s_*: one correspondence per transaction, s_tlast ends a batch
// - result stream m_*: one transaction per batch with the cost and gradient
//   totals, m_tuser flags a point of the batch that had zero projected depth
// - cfg_*: register writes, only while the unit is idle
// - an item passes through four divisions on the shared restoring divider,
//   33x33 multiplies issued one per cycle and three one-bit normalize loops;
//   a zero-depth item skips the divisions and goes straight to the finish
// - s_tready is high only while the sequencer idles
// - the result sits in an output register; the next item is accepted while it
//   waits, and only the end of the next batch waits on m_tready
// - reset: synchronous, active low; clears sums, flag, sequencer and registers
//   to their defaults (sigma 1.0, everything else 0)
module lorentzian_homography_cost_gradient_unit (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         cfg_wr_en,
    input  logic [2:0]   cfg_addr,
    input  logic [31:0]  cfg_wdata,
    input  logic         s_tvalid,
    output logic         s_tready,
    // left_x, left_y, left_w, fixed_x, fixed_y, fixed_w, target_u, target_v
    input  logic [255:0] s_tdata,
    input  logic         s_tlast,
    output logic         m_tvalid,
    input  logic         m_tready,
    // cost_total, grad_x, grad_y, grad_z
    output logic [255:0] m_tdata,
    // degenerate_seen
    output logic         m_tuser
);

    localparam logic [5:0] S_IDLE = 6'd0;
    localparam logic [5:0] S_D0   = 6'd1;
    localparam logic [5:0] S_D1   = 6'd2;
    localparam logic [5:0] S_D2   = 6'd3;
    localparam logic [5:0] S_D3   = 6'd4;
    localparam logic [5:0] S_H0   = 6'd5;
    localparam logic [5:0] S_H1   = 6'd6;
    localparam logic [5:0] S_H2   = 6'd7;
    localparam logic [5:0] S_H3   = 6'd8;
    localparam logic [5:0] S_CHK  = 6'd9;
    localparam logic [5:0] S_DIV  = 6'd10;
    localparam logic [5:0] S_DVD  = 6'd11;
    localparam logic [5:0] S_Z0   = 6'd12;
    localparam logic [5:0] S_Z1   = 6'd13;
    localparam logic [5:0] S_Z2   = 6'd14;
    localparam logic [5:0] S_Z3   = 6'd15;
    localparam logic [5:0] S_Z4   = 6'd16;
    localparam logic [5:0] S_R0   = 6'd17;
    localparam logic [5:0] S_R1   = 6'd18;
    localparam logic [5:0] S_NRM  = 6'd19;
    localparam logic [5:0] S_L0   = 6'd20;
    localparam logic [5:0] S_L1   = 6'd21;
    localparam logic [5:0] S_L2   = 6'd22;
    localparam logic [5:0] S_L3   = 6'd23;
    localparam logic [5:0] S_L4   = 6'd24;
    localparam logic [5:0] S_G0   = 6'd25;
    localparam logic [5:0] S_G1   = 6'd26;
    localparam logic [5:0] S_G2   = 6'd27;
    localparam logic [5:0] S_HZN  = 6'd28;
    localparam logic [5:0] S_DEN  = 6'd29;
    localparam logic [5:0] S_DNN  = 6'd30;
    localparam logic [5:0] S_P0   = 6'd31;
    localparam logic [5:0] S_P1   = 6'd32;
    localparam logic [5:0] S_P2   = 6'd33;
    localparam logic [5:0] S_P3   = 6'd34;
    localparam logic [5:0] S_FIN  = 6'd35;

    localparam logic [1:0] DIV_RX = 2'd0;
    localparam logic [1:0] DIV_RY = 2'd1;
    localparam logic [1:0] DIV_X  = 2'd2;
    localparam logic [1:0] DIV_G  = 2'd3;

    logic [5:0]         state_reg;
    logic signed [31:0] nx_reg, ny_reg, nz_reg, mx_reg, my_reg, mz_reg;
    logic [30:0]        lsig_reg;

    logic signed [31:0] p0_reg, p1_reg, p2_reg, fx_reg, fy_reg, fz_reg, tu_reg, tv_reg;
    logic               last_reg;
    logic signed [31:0] d_reg, hx_reg, hy_reg, hz_reg, rx_reg, ry_reg, z1_reg, z2_reg;
    logic [29:0]        half_reg;
    logic signed [49:0] acc_reg;
    logic [46:0]        x_reg;
    logic [4:0]         nrm_cnt_reg;
    logic [30:0]        a_reg;
    logic [47:0]        anum_reg;
    logic               neg_reg;
    logic [46:0]        hz2_reg;
    logic [47:0]        den_reg;
    logic signed [31:0] g_reg;

    logic signed [63:0] cost_reg, gx_reg, gy_reg, gz_reg;
    logic               degen_reg;
    logic               m_valid_reg;
    logic [255:0]       m_data_reg;
    logic               m_user_reg;

    logic signed [65:0] prod_reg;
    logic signed [32:0] mul_a, mul_b;

    logic [39:0]        div_rem_reg;
    logic [63:0]        div_quo_reg;
    logic [39:0]        div_den_reg;
    logic [5:0]         div_cnt_reg;
    logic [1:0]         div_sel_reg;
    logic               div_neg_reg;

    logic [40:0]        div_shift;
    logic               div_ge;
    logic [40:0]        div_diff;

    logic signed [47:0] prod_q;
    logic signed [31:0] mq;
    logic [30:0]        sig;
    logic [31:0]        sh;
    logic signed [48:0] qm, qs;
    logic signed [31:0] qsat;
    logic signed [31:0] r2;
    logic [31:0]        fq;
    logic [8:0]         tab_idx;
    logic [31:0]        tab_a, tab_b;
    logic [38:0]        ln_val;
    logic signed [48:0] num;
    logic [30:0]        gm;
    logic [31:0]        abs_hx, abs_hy, abs_hz;
    logic               out_load;

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;

    assign out_load = (state_reg == S_FIN) && last_reg && (!m_valid_reg || m_tready);

    assign prod_q = prod_reg[63:16];
    assign mq     = lhcg_pkg::sat32({{16{prod_q[47]}}, prod_q});
    assign sig    = (lsig_reg == 31'd0) ? 31'd1 : lsig_reg;
    assign sh     = {1'b0, sig} + {2'b00, half_reg};
    assign r2     = lhcg_pkg::add_sat32(acc_reg[31:0], mq);

    assign div_shift = {div_rem_reg, div_quo_reg[63]};
    assign div_ge    = div_shift >= {1'b0, div_den_reg};
    assign div_diff  = div_shift - {1'b0, div_den_reg};

    assign qm   = {1'b0, div_quo_reg[47:0]};
    assign qs   = div_neg_reg ? -qm : qm;
    assign qsat = lhcg_pkg::sat32({{15{qs[48]}}, qs});

    assign fq      = x_reg[45:14];
    assign tab_idx = {1'b0, fq[31:24]};
    assign tab_a   = lhcg_pkg::LOG_TAB[tab_idx];
    assign tab_b   = lhcg_pkg::LOG_TAB[tab_idx + 9'd1];
    assign ln_val  = {1'b0, prod_reg[37:0]} + {7'd0, acc_reg[31:0]};

    assign num = acc_reg[48:0] + {prod_q[47], prod_q};
    assign gm  = (div_quo_reg[63:31] != 33'd0) ? 31'h7fffffff : div_quo_reg[30:0];

    assign abs_hx = hx_reg[31] ? 32'(-hx_reg) : hx_reg;
    assign abs_hy = hy_reg[31] ? 32'(-hy_reg) : hy_reg;
    assign abs_hz = hz_reg[31] ? 32'(-hz_reg) : hz_reg;

    // multiplier operand select
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            S_D0: begin mul_a = {nx_reg[31], nx_reg}; mul_b = {p0_reg[31], p0_reg}; end
            S_D1: begin mul_a = {ny_reg[31], ny_reg}; mul_b = {p1_reg[31], p1_reg}; end
            S_D2: begin mul_a = {nz_reg[31], nz_reg}; mul_b = {p2_reg[31], p2_reg}; end
            S_H0: begin mul_a = {mx_reg[31], mx_reg}; mul_b = {d_reg[31], d_reg}; end
            S_H1: begin mul_a = {my_reg[31], my_reg}; mul_b = {d_reg[31], d_reg}; end
            S_H2: begin mul_a = {mz_reg[31], mz_reg}; mul_b = {d_reg[31], d_reg}; end
            S_Z0: begin mul_a = {mx_reg[31], mx_reg}; mul_b = {hz_reg[31], hz_reg}; end
            S_Z1: begin mul_a = {hx_reg[31], hx_reg}; mul_b = {mz_reg[31], mz_reg}; end
            S_Z2: begin mul_a = {my_reg[31], my_reg}; mul_b = {hz_reg[31], hz_reg}; end
            S_Z3: begin mul_a = {hy_reg[31], hy_reg}; mul_b = {mz_reg[31], mz_reg}; end
            S_Z4: begin mul_a = {rx_reg[31], rx_reg}; mul_b = {rx_reg[31], rx_reg}; end
            S_R0: begin mul_a = {ry_reg[31], ry_reg}; mul_b = {ry_reg[31], ry_reg}; end
            S_L0: begin
                mul_a = {2'b00, 31'(tab_b - tab_a)};
                mul_b = {9'd0, fq[23:0]};
            end
            S_L2: begin mul_a = {2'b00, a_reg}; mul_b = {1'b0, lhcg_pkg::LN2_Q32}; end
            S_L3: begin
                mul_a = {28'd0, 5'd30 - nrm_cnt_reg};
                mul_b = {1'b0, lhcg_pkg::LN2_Q32};
            end
            S_L4: begin mul_a = {rx_reg[31], rx_reg}; mul_b = {z1_reg[31], z1_reg}; end
            S_G0: begin mul_a = {ry_reg[31], ry_reg}; mul_b = {z2_reg[31], z2_reg}; end
            S_G1: begin mul_a = {hz_reg[31], hz_reg}; mul_b = {hz_reg[31], hz_reg}; end
            S_HZN: begin mul_a = {1'b0, hz2_reg[31:0]}; mul_b = {1'b0, sh}; end
            S_P0: begin mul_a = {p0_reg[31], p0_reg}; mul_b = {g_reg[31], g_reg}; end
            S_P1: begin mul_a = {p1_reg[31], p1_reg}; mul_b = {g_reg[31], g_reg}; end
            S_P2: begin mul_a = {p2_reg[31], p2_reg}; mul_b = {g_reg[31], g_reg}; end
            default: begin mul_a = '0; mul_b = '0; end
        endcase
    end

    always_ff @(posedge aclk) begin
        prod_reg <= mul_a * mul_b;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            nx_reg      <= '0;
            ny_reg      <= '0;
            nz_reg      <= '0;
            mx_reg      <= '0;
            my_reg      <= '0;
            mz_reg      <= '0;
            lsig_reg    <= 31'd65536;
            cost_reg    <= '0;
            gx_reg      <= '0;
            gy_reg      <= '0;
            gz_reg      <= '0;
            degen_reg   <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                case (cfg_addr)
                    lhcg_pkg::REG_NORMAL_X: nx_reg <= cfg_wdata;
                    lhcg_pkg::REG_NORMAL_Y: ny_reg <= cfg_wdata;
                    lhcg_pkg::REG_NORMAL_Z: nz_reg <= cfg_wdata;
                    lhcg_pkg::REG_MOTION_X: mx_reg <= cfg_wdata;
                    lhcg_pkg::REG_MOTION_Y: my_reg <= cfg_wdata;
                    lhcg_pkg::REG_MOTION_Z: mz_reg <= cfg_wdata;
                    lhcg_pkg::REG_SIGMA:    lsig_reg <= cfg_wdata[30:0];
                    default: ;
                endcase
            end

            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end

            case (state_reg)
                S_IDLE: begin
                    if (s_tvalid) begin
                        p0_reg   <= s_tdata[31:0];
                        p1_reg   <= s_tdata[63:32];
                        p2_reg   <= s_tdata[95:64];
                        fx_reg   <= s_tdata[127:96];
                        fy_reg   <= s_tdata[159:128];
                        fz_reg   <= s_tdata[191:160];
                        tu_reg   <= s_tdata[223:192];
                        tv_reg   <= s_tdata[255:224];
                        last_reg <= s_tlast;
                        state_reg <= S_D0;
                    end
                end
                S_D0: state_reg <= S_D1;
                S_D1: begin
                    acc_reg   <= {{2{prod_q[47]}}, prod_q};
                    state_reg <= S_D2;
                end
                S_D2: begin
                    acc_reg   <= acc_reg + {{2{prod_q[47]}}, prod_q};
                    state_reg <= S_D3;
                end
                S_D3: begin
                    d_reg <= lhcg_pkg::sat32(64'($signed(acc_reg + {{2{prod_q[47]}}, prod_q})));
                    state_reg <= S_H0;
                end
                S_H0: state_reg <= S_H1;
                S_H1: begin
                    hx_reg    <= lhcg_pkg::sub_sat32(fx_reg, mq);
                    state_reg <= S_H2;
                end
                S_H2: begin
                    hy_reg    <= lhcg_pkg::sub_sat32(fy_reg, mq);
                    state_reg <= S_H3;
                end
                S_H3: begin
                    hz_reg    <= lhcg_pkg::sub_sat32(fz_reg, mq);
                    state_reg <= S_CHK;
                end
                S_CHK: begin
                    if (hz_reg == 32'sd0) begin
                        degen_reg <= 1'b1;
                        state_reg <= S_FIN;
                    end else begin
                        div_quo_reg <= {16'd0, abs_hx, 16'd0};
                        div_rem_reg <= '0;
                        div_den_reg <= {8'd0, abs_hz};
                        div_cnt_reg <= '0;
                        div_neg_reg <= hx_reg[31] ^ hz_reg[31];
                        div_sel_reg <= DIV_RX;
                        state_reg   <= S_DIV;
                    end
                end
                S_DIV: begin
                    div_rem_reg <= div_ge ? div_diff[39:0] : div_shift[39:0];
                    div_quo_reg <= {div_quo_reg[62:0], div_ge};
                    div_cnt_reg <= div_cnt_reg + 6'd1;
                    if (div_cnt_reg == 6'd63) begin
                        state_reg <= S_DVD;
                    end
                end
                S_DVD: begin
                    div_rem_reg <= '0;
                    div_cnt_reg <= '0;
                    case (div_sel_reg)
                        DIV_RX: begin
                            rx_reg      <= lhcg_pkg::sub_sat32(tu_reg, qsat);
                            div_quo_reg <= {16'd0, abs_hy, 16'd0};
                            div_den_reg <= {8'd0, abs_hz};
                            div_neg_reg <= hy_reg[31] ^ hz_reg[31];
                            div_sel_reg <= DIV_RY;
                            state_reg   <= S_DIV;
                        end
                        DIV_RY: begin
                            ry_reg    <= lhcg_pkg::sub_sat32(tv_reg, qsat);
                            state_reg <= S_Z0;
                        end
                        DIV_X: begin
                            x_reg       <= 47'd65536 + div_quo_reg[46:0];
                            nrm_cnt_reg <= '0;
                            state_reg   <= S_NRM;
                        end
                        default: begin
                            g_reg     <= neg_reg ? -$signed({1'b0, gm}) : $signed({1'b0, gm});
                            state_reg <= S_P0;
                        end
                    endcase
                end
                S_Z0: state_reg <= S_Z1;
                S_Z1: begin
                    acc_reg   <= {{18{mq[31]}}, mq};
                    state_reg <= S_Z2;
                end
                S_Z2: begin
                    z1_reg    <= lhcg_pkg::sub_sat32(acc_reg[31:0], mq);
                    state_reg <= S_Z3;
                end
                S_Z3: begin
                    acc_reg   <= {{18{mq[31]}}, mq};
                    state_reg <= S_Z4;
                end
                S_Z4: begin
                    z2_reg    <= lhcg_pkg::sub_sat32(acc_reg[31:0], mq);
                    state_reg <= S_R0;
                end
                S_R0: begin
                    acc_reg   <= {{18{mq[31]}}, mq};
                    state_reg <= S_R1;
                end
                S_R1: begin
                    half_reg    <= r2[30:1];
                    div_quo_reg <= {18'd0, r2[30:1], 16'd0};
                    div_den_reg <= {9'd0, sig};
                    div_neg_reg <= 1'b0;
                    div_sel_reg <= DIV_X;
                    state_reg   <= S_DIV;
                end
                S_NRM: begin
                    if (x_reg[46]) begin
                        state_reg <= S_L0;
                    end else begin
                        x_reg       <= {x_reg[45:0], 1'b0};
                        nrm_cnt_reg <= nrm_cnt_reg + 5'd1;
                    end
                end
                S_L0: begin
                    a_reg     <= tab_a[30:0];
                    state_reg <= S_L1;
                end
                S_L1: begin
                    a_reg     <= a_reg + prod_reg[54:24];
                    state_reg <= S_L2;
                end
                S_L2: state_reg <= S_L3;
                S_L3: begin
                    acc_reg   <= {18'd0, prod_reg[61:30]};
                    state_reg <= S_L4;
                end
                S_L4: begin
                    cost_reg  <= lhcg_pkg::sat_add64(cost_reg, {25'd0, ln_val});
                    state_reg <= S_G0;
                end
                S_G0: begin
                    acc_reg   <= {{2{prod_q[47]}}, prod_q};
                    state_reg <= S_G1;
                end
                S_G1: begin
                    neg_reg   <= num[48];
                    anum_reg  <= num[48] ? 48'(-num) : num[47:0];
                    state_reg <= S_G2;
                end
                S_G2: begin
                    hz2_reg   <= prod_reg[62:16];
                    state_reg <= S_HZN;
                end
                S_HZN: begin
                    if (hz2_reg[46:32] != 15'd0) begin
                        hz2_reg  <= {1'b0, hz2_reg[46:1]};
                        anum_reg <= {1'b0, anum_reg[47:1]};
                    end else begin
                        state_reg <= S_DEN;
                    end
                end
                S_DEN: begin
                    den_reg   <= prod_reg[63:16];
                    state_reg <= S_DNN;
                end
                S_DNN: begin
                    if (den_reg[47:39] != 9'd0) begin
                        den_reg  <= {1'b0, den_reg[47:1]};
                        anum_reg <= {1'b0, anum_reg[47:1]};
                    end else begin
                        div_quo_reg <= {anum_reg, 16'd0};
                        div_den_reg <= (den_reg == 48'd0) ? 40'd1 : den_reg[39:0];
                        div_neg_reg <= 1'b0;
                        div_sel_reg <= DIV_G;
                        state_reg   <= S_DIV;
                    end
                end
                S_P0: state_reg <= S_P1;
                S_P1: begin
                    gx_reg    <= lhcg_pkg::sat_add64(gx_reg, prod_reg[63:0]);
                    state_reg <= S_P2;
                end
                S_P2: begin
                    gy_reg    <= lhcg_pkg::sat_add64(gy_reg, prod_reg[63:0]);
                    state_reg <= S_P3;
                end
                S_P3: begin
                    gz_reg    <= lhcg_pkg::sat_add64(gz_reg, prod_reg[63:0]);
                    state_reg <= S_FIN;
                end
                S_FIN: begin
                    if (!last_reg) begin
                        state_reg <= S_IDLE;
                    end else if (out_load) begin
                        m_data_reg  <= {gz_reg, gy_reg, gx_reg, cost_reg};
                        m_user_reg  <= degen_reg;
                        cost_reg    <= '0;
                        gx_reg      <= '0;
                        gy_reg      <= '0;
                        gz_reg      <= '0;
                        degen_reg   <= 1'b0;
                        state_reg   <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

endmodule
